>>> src/rqp_pkg.sv
// Shared constants, widths and the sine table for the rotated quad projection.
// Depends on nothing; every other file imports it.
`default_nettype none

package rqp_pkg;

   // Fixed-point formats and fixed field widths.
   localparam int SINE_FRAC_BITS  = 14;
   localparam int COORD_FRAC_BITS = 8;
   localparam int CAMERA_DISTANCE = 2000;
   localparam int CAM_W           = 11;
   localparam int RECT_W          = 13;
   localparam int ANGLE_W         = 9;
   localparam int OFFSET_W        = 14;
   localparam int SCREEN_W        = 16;
   localparam int CSR_INDEX_W     = 2;

   // Derived datapath widths.
   localparam int ROM_W     = SINE_FRAC_BITS + 1;
   localparam int SIN_W     = SINE_FRAC_BITS + 2;
   localparam int TP_W      = 2 * SIN_W + 1;
   localparam int HALF_W    = RECT_W + COORD_FRAC_BITS;
   localparam int PROD_W    = HALF_W + SIN_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int COORD_W   = SUM_W - SINE_FRAC_BITS;
   localparam int ZC_W      = COORD_W + 2;
   localparam int NUM_W     = COORD_W + CAM_W + COORD_FRAC_BITS;
   localparam int QUOT_BITS = COORD_FRAC_BITS + 17;
   localparam int QS_W      = QUOT_BITS + 1;
   localparam int SCR_W     = QS_W + 1;

   // Pipeline depths: front stages, divider, output register.
   localparam int FRONT_LAT   = 6;
   localparam int DIV_LAT     = QUOT_BITS + 2;
   localparam int RSP_LATENCY = FRONT_LAT + DIV_LAT + 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_HEIGHT = 2'd1;

   localparam logic [RECT_W-1:0] RECT_RESET = 13'd256;

   typedef logic [ROM_W-1:0] sin_rom_type [0:90];

   // Quarter-wave sine in Q1.F, built at elaboration by a Taylor series in Q.30.
   function automatic sin_rom_type build_sin_rom();
      sin_rom_type rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      for (int r = 0; r <= 90; r++) begin
         x    = (64'(r) * 64'hC90FDAA2) / 64'd180;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 10; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rom[r] = ROM_W'((sum + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS));
      end
      return rom;
   endfunction

   localparam sin_rom_type SIN_ROM = build_sin_rom();

   // Folds an angle of up to 511 degrees into 0..359.
   function automatic logic [ANGLE_W-1:0] angle_wrap(input logic [ANGLE_W-1:0] a);
      return (a >= ANGLE_W'(360)) ? a - ANGLE_W'(360) : a;
   endfunction

   // Sine of a whole-degree angle in 0..359, by quadrant symmetry.
   function automatic logic signed [SIN_W-1:0] sin_deg(input logic [ANGLE_W-1:0] d);
      logic [ANGLE_W-1:0] idx;
      logic               neg;
      logic signed [SIN_W-1:0] mag;
      if (d < ANGLE_W'(90)) begin
         idx = d;
         neg = 1'b0;
      end else if (d < ANGLE_W'(180)) begin
         idx = ANGLE_W'(180) - d;
         neg = 1'b0;
      end else if (d < ANGLE_W'(270)) begin
         idx = d - ANGLE_W'(180);
         neg = 1'b1;
      end else begin
         idx = ANGLE_W'(360) - d;
         neg = 1'b1;
      end
      mag = $signed({1'b0, SIN_ROM[idx[6:0]]});
      return neg ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

>>> src/rqp_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on rqp_pkg; a quotient too large for QUOT_BITS is clamped in magnitude.
`default_nettype none

module rqp_div (
   input  wire logic                                 clock,
   input  wire logic signed [rqp_pkg::NUM_W-1:0]     num,
   input  wire logic signed [rqp_pkg::ZC_W-1:0]      den,
   output logic signed      [rqp_pkg::QS_W-1:0]      quot
);
   import rqp_pkg::*;

   logic [NUM_W-1:0]     rem_ff  [0:QUOT_BITS];
   logic [NUM_W-1:0]     rem_in  [0:QUOT_BITS];
   logic [ZC_W-1:0]      dmag_ff [0:QUOT_BITS];
   logic [ZC_W-1:0]      dmag_in [0:QUOT_BITS];
   logic [QUOT_BITS-1:0] q_ff    [0:QUOT_BITS];
   logic [QUOT_BITS-1:0] q_in    [0:QUOT_BITS];
   logic [QUOT_BITS:0]   neg_ff;
   logic [QUOT_BITS:0]   neg_in;
   logic [QUOT_BITS:0]   ovf_ff;
   logic [QUOT_BITS:0]   ovf_in;
   logic signed [QS_W-1:0] quot_ff;
   logic signed [QS_W-1:0] quot_in;

   // Entry stage takes magnitudes, result sign and the overflow check.
   // Restoring steps follow: stage s settles quotient bit QUOT_BITS-1-s.
   always_comb begin
      rem_in[0]  = (num < 0) ? NUM_W'(-num) : NUM_W'(num);
      dmag_in[0] = (den < 0) ? ZC_W'(-den) : ZC_W'(den);
      q_in[0]    = '0;
      neg_in[0]  = num[NUM_W-1] ^ den[ZC_W-1];
      ovf_in[0]  = (rem_in[0] >> QUOT_BITS) >= NUM_W'(dmag_in[0]);
      for (int s = 0; s < QUOT_BITS; s++) begin
         if ((rem_ff[s] >> (QUOT_BITS - 1 - s)) >= NUM_W'(dmag_ff[s])) begin
            rem_in[s+1] = rem_ff[s] - (NUM_W'(dmag_ff[s]) << (QUOT_BITS - 1 - s));
            q_in[s+1]   = q_ff[s] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - s));
         end else begin
            rem_in[s+1] = rem_ff[s];
            q_in[s+1]   = q_ff[s];
         end
         dmag_in[s+1] = dmag_ff[s];
         neg_in[s+1]  = neg_ff[s];
         ovf_in[s+1]  = ovf_ff[s];
      end
   end

   // Output stage: clamp on overflow and apply the sign.
   always_comb begin
      logic [QUOT_BITS-1:0] qm;
      qm      = ovf_ff[QUOT_BITS] ? '1 : q_ff[QUOT_BITS];
      quot_in = neg_ff[QUOT_BITS] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= QUOT_BITS; s++) begin
         rem_ff[s]  <= rem_in[s];
         dmag_ff[s] <= dmag_in[s];
         q_ff[s]    <= q_in[s];
      end
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

>>> src/rotated_quad_projection.sv
// Rotated quad projection: rotation matrix, corner transform, perspective divide.
// One item per cycle: six front stages, the 25-step divider plus its entry and
// output stages, and the output register lie between an accepted start and the
// result strobe. The receiver cannot stall; busy stays low.
// Synchronous reset clears all valid bits and sets width and height to 256.
`default_nettype none

module rotated_quad_projection (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [rqp_pkg::ANGLE_W-1:0]           req_angle_x,
   input  wire logic [rqp_pkg::ANGLE_W-1:0]           req_angle_y,
   input  wire logic [rqp_pkg::ANGLE_W-1:0]           req_angle_z,
   input  wire logic signed [rqp_pkg::OFFSET_W-1:0]   req_depth_offset,
   output logic                                       rsp_strobe,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_a_x,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_a_y,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_b_x,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_b_y,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_c_x,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_c_y,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_d_x,
   output logic signed [rqp_pkg::SCREEN_W-1:0]        rsp_corner_d_y,
   output logic                                       rsp_zero_depth_flag,
   input  wire logic                                  csr_we,
   input  wire logic [rqp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [rqp_pkg::RECT_W-1:0]            csr_wdata
);
   import rqp_pkg::*;

   localparam int ROUND_HALF = 2 ** (SINE_FRAC_BITS - 1);
   localparam int FRAC_MASK  = 2 ** COORD_FRAC_BITS - 1;
   localparam logic signed [ZC_W-1:0]  CAM_Z = ZC_W'(CAMERA_DISTANCE * (2 ** COORD_FRAC_BITS));
   localparam logic signed [NUM_W-1:0] CAM_N = NUM_W'(CAMERA_DISTANCE * (2 ** COORD_FRAC_BITS));
   // Corner order a, b, c, d: which corners sit at negative x and negative y.
   localparam logic [3:0] NEG_X = 4'b1001;
   localparam logic [3:0] NEG_Y = 4'b1100;

   typedef struct {
      logic signed [SIN_W-1:0]    cx, sx, cy, sy, cz, sz;
      logic signed [OFFSET_W-1:0] off;
   } s1_type;

   typedef struct {
      logic signed [SIN_W-1:0]    t00, t01, t02, t11, t12, cz, sz;
      logic signed [OFFSET_W-1:0] off;
   } s2_type;

   typedef struct {
      logic signed [SIN_W-1:0]    m00, m01, m02, m10, m11, m12;
      logic signed [OFFSET_W-1:0] off;
   } s3_type;

   typedef struct {
      logic signed [PROD_W-1:0]   a0, a1, a2, b0, b1, b2;
      logic signed [OFFSET_W-1:0] off;
   } s4_type;

   typedef struct {
      logic signed [COORD_W-1:0] xw [4];
      logic signed [COORD_W-1:0] yw [4];
      logic signed [ZC_W-1:0]    zc [4];
   } s5_type;

   typedef struct {
      logic signed [NUM_W-1:0] numx [4];
      logic signed [NUM_W-1:0] numy [4];
      logic signed [ZC_W-1:0]  den  [4];
      logic [3:0]              zero;
   } s6_type;

   logic [RECT_W-1:0] rect_width_ff, rect_height_ff;
   logic [FRONT_LAT-1:0] vld_ff, vld_in;
   logic [DIV_LAT-1:0]   dvld_ff, dvld_in;
   logic [3:0]           dzero_ff [0:DIV_LAT-1];
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   logic signed [QS_W-1:0]     quot_x [4];
   logic signed [QS_W-1:0]     quot_y [4];
   logic signed [SCREEN_W-1:0] out_x_ff [4];
   logic signed [SCREEN_W-1:0] out_x_in [4];
   logic signed [SCREEN_W-1:0] out_y_ff [4];
   logic signed [SCREEN_W-1:0] out_y_in [4];
   logic flag_ff, flag_in;
   logic strobe_ff;
   logic accept;

   function automatic logic signed [SIN_W-1:0] rnd_sine(input logic signed [TP_W-1:0] v);
      return SIN_W'((v + TP_W'(ROUND_HALF)) >>> SINE_FRAC_BITS);
   endfunction

   // Truncate toward zero to an integer pixel, then saturate to 16 bits.
   function automatic logic signed [SCREEN_W-1:0] to_screen(input logic signed [SCR_W-1:0] v);
      logic signed [SCR_W-1:0] t;
      t = (v < 0) ? ((v + SCR_W'(FRAC_MASK)) >>> COORD_FRAC_BITS) : (v >>> COORD_FRAC_BITS);
      if (t > SCR_W'(32767)) begin
         return SCREEN_W'(32767);
      end else if (t < SCR_W'(-32768)) begin
         return SCREEN_W'(-32768);
      end
      return SCREEN_W'(t);
   endfunction

   assign accept = start && !busy;
   assign busy   = 1'b0;

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rect_width_ff  <= RECT_RESET;
         rect_height_ff <= RECT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RECT_WIDTH:  rect_width_ff  <= csr_wdata;
            CSR_RECT_HEIGHT: rect_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: sine and cosine lookups for the three angles.
   always_comb begin
      logic [ANGLE_W-1:0] ax, ay, az;
      ax = angle_wrap(req_angle_x);
      ay = angle_wrap(req_angle_y);
      az = angle_wrap(req_angle_z);
      s1_in.sx  = sin_deg(ax);
      s1_in.cx  = sin_deg(angle_wrap(ax + ANGLE_W'(90)));
      s1_in.sy  = sin_deg(ay);
      s1_in.cy  = sin_deg(angle_wrap(ay + ANGLE_W'(90)));
      s1_in.sz  = sin_deg(az);
      s1_in.cz  = sin_deg(angle_wrap(az + ANGLE_W'(90)));
      s1_in.off = req_depth_offset;
   end

   // Stage 2: rows 0 and 1 of RotY*RotX; the other entries are exact copies.
   always_comb begin
      s2_in.t00 = s1_ff.cy;
      s2_in.t01 = rnd_sine(TP_W'(s1_ff.sy) * TP_W'(s1_ff.sx));
      s2_in.t02 = rnd_sine(-(TP_W'(s1_ff.sy) * TP_W'(s1_ff.cx)));
      s2_in.t11 = s1_ff.cx;
      s2_in.t12 = s1_ff.sx;
      s2_in.cz  = s1_ff.cz;
      s2_in.sz  = s1_ff.sz;
      s2_in.off = s1_ff.off;
   end

   // Stage 3: rows 0 and 1 of the product with RotZ.
   always_comb begin
      s3_in.m00 = rnd_sine(TP_W'(s2_ff.t00) * TP_W'(s2_ff.cz)
                           - TP_W'(s2_ff.t01) * TP_W'(s2_ff.sz));
      s3_in.m01 = rnd_sine(TP_W'(s2_ff.t00) * TP_W'(s2_ff.sz)
                           + TP_W'(s2_ff.t01) * TP_W'(s2_ff.cz));
      s3_in.m02 = s2_ff.t02;
      s3_in.m10 = rnd_sine(-(TP_W'(s2_ff.t11) * TP_W'(s2_ff.sz)));
      s3_in.m11 = rnd_sine(TP_W'(s2_ff.t11) * TP_W'(s2_ff.cz));
      s3_in.m12 = s2_ff.t12;
      s3_in.off = s2_ff.off;
   end

   // Stage 4: half width and half height times the matrix entries.
   always_comb begin
      logic signed [HALF_W-1:0] hw, hh;
      hw = $signed({1'b0, rect_width_ff, {(COORD_FRAC_BITS - 1){1'b0}}});
      hh = $signed({1'b0, rect_height_ff, {(COORD_FRAC_BITS - 1){1'b0}}});
      s4_in.a0  = PROD_W'(hw) * PROD_W'(s3_ff.m00);
      s4_in.a1  = PROD_W'(hw) * PROD_W'(s3_ff.m01);
      s4_in.a2  = PROD_W'(hw) * PROD_W'(s3_ff.m02);
      s4_in.b0  = PROD_W'(hh) * PROD_W'(s3_ff.m10);
      s4_in.b1  = PROD_W'(hh) * PROD_W'(s3_ff.m11);
      s4_in.b2  = PROD_W'(hh) * PROD_W'(s3_ff.m12);
      s4_in.off = s3_ff.off;
   end

   // Stage 5: rotated corners rounded to Q.C, and camera depth.
   always_comb begin
      logic signed [SUM_W-1:0]   ex, ey, ez;
      logic signed [COORD_W-1:0] zw;
      for (int i = 0; i < 4; i++) begin
         ex = (NEG_X[i] ? -SUM_W'(s4_ff.a0) : SUM_W'(s4_ff.a0))
            + (NEG_Y[i] ? -SUM_W'(s4_ff.b0) : SUM_W'(s4_ff.b0));
         ey = (NEG_X[i] ? -SUM_W'(s4_ff.a1) : SUM_W'(s4_ff.a1))
            + (NEG_Y[i] ? -SUM_W'(s4_ff.b1) : SUM_W'(s4_ff.b1));
         ez = (NEG_X[i] ? -SUM_W'(s4_ff.a2) : SUM_W'(s4_ff.a2))
            + (NEG_Y[i] ? -SUM_W'(s4_ff.b2) : SUM_W'(s4_ff.b2));
         s5_in.xw[i] = COORD_W'((ex + SUM_W'(ROUND_HALF)) >>> SINE_FRAC_BITS);
         s5_in.yw[i] = COORD_W'((ey + SUM_W'(ROUND_HALF)) >>> SINE_FRAC_BITS);
         zw          = COORD_W'((ez + SUM_W'(ROUND_HALF)) >>> SINE_FRAC_BITS);
         s5_in.zc[i] = ZC_W'(zw) + (ZC_W'(s4_ff.off) <<< COORD_FRAC_BITS) + CAM_Z;
      end
   end

   // Stage 6: scaled numerators and the zero-depth test.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s6_in.numx[i] = NUM_W'(s5_ff.xw[i]) * CAM_N;
         s6_in.numy[i] = NUM_W'(s5_ff.yw[i]) * CAM_N;
         s6_in.den[i]  = s5_ff.zc[i];
         s6_in.zero[i] = (s5_ff.zc[i] == '0);
      end
   end

   // Front pipeline registers; valid bits reset, payload does not.
   assign vld_in = {vld_ff[FRONT_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
      s6_ff <= s6_in;
   end

   // Eight perspective dividers, two per corner.
   for (genvar i = 0; i < 4; i++) begin : g_div
      rqp_div u_div_x (
         .clock (clock),
         .num   (s6_ff.numx[i]),
         .den   (s6_ff.den[i]),
         .quot  (quot_x[i])
      );
      rqp_div u_div_y (
         .clock (clock),
         .num   (s6_ff.numy[i]),
         .den   (s6_ff.den[i]),
         .quot  (quot_y[i])
      );
   end

   // Valid and zero-depth bits ride alongside the divider.
   assign dvld_in = {dvld_ff[DIV_LAT-2:0], vld_ff[FRONT_LAT-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else begin
         dvld_ff <= dvld_in;
      end
      dzero_ff[0] <= s6_ff.zero;
      for (int s = 1; s < DIV_LAT; s++) begin
         dzero_ff[s] <= dzero_ff[s-1];
      end
   end

   // Output stage: screen offset, truncation and saturation.
   always_comb begin
      logic signed [SCR_W-1:0] ofs_x, ofs_y;
      ofs_x = $signed(SCR_W'({rect_width_ff[RECT_W-1:1], {COORD_FRAC_BITS{1'b0}}}));
      ofs_y = $signed(SCR_W'({rect_height_ff[RECT_W-1:1], {COORD_FRAC_BITS{1'b0}}}));
      for (int i = 0; i < 4; i++) begin
         if (dzero_ff[DIV_LAT-1][i]) begin
            out_x_in[i] = '0;
            out_y_in[i] = '0;
         end else begin
            out_x_in[i] = to_screen(SCR_W'(quot_x[i]) + ofs_x);
            out_y_in[i] = to_screen(ofs_y - SCR_W'(quot_y[i]));
         end
      end
      flag_in = |dzero_ff[DIV_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dvld_ff[DIV_LAT-1];
      end
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      flag_ff  <= flag_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_corner_a_x      = out_x_ff[0];
   assign rsp_corner_a_y      = out_y_ff[0];
   assign rsp_corner_b_x      = out_x_ff[1];
   assign rsp_corner_b_y      = out_y_ff[1];
   assign rsp_corner_c_x      = out_x_ff[2];
   assign rsp_corner_c_y      = out_y_ff[2];
   assign rsp_corner_d_x      = out_x_ff[3];
   assign rsp_corner_d_y      = out_y_ff[3];
   assign rsp_zero_depth_flag = flag_ff;

endmodule

`default_nettype wire

>>> src/rqp_checker.sv
// Port-level checks for the rotated quad projection, bound to the top level.
// Depends on rqp_pkg for the fixed pipeline latency.
`default_nettype none

module rqp_port_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  start,
   input wire logic                                  busy,
   input wire logic                                  rsp_strobe,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_a_x,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_a_y,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_b_x,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_b_y,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_c_x,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_c_y,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_d_x,
   input wire logic signed [rqp_pkg::SCREEN_W-1:0]   rsp_corner_d_y,
   input wire logic                                  rsp_zero_depth_flag
);
   import rqp_pkg::*;

   // Every accepted beat yields a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_strobe)
      else $error("accepted beat produced no result");

   // No result appears without a beat accepted the fixed latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##RSP_LATENCY !rsp_strobe)
      else $error("result strobe without an accepted beat");

   // A zero-depth flag means at least one corner was forced to the origin.
   a_flag_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_zero_depth_flag) |->
         ((rsp_corner_a_x == 0 && rsp_corner_a_y == 0) ||
          (rsp_corner_b_x == 0 && rsp_corner_b_y == 0) ||
          (rsp_corner_c_x == 0 && rsp_corner_c_y == 0) ||
          (rsp_corner_d_x == 0 && rsp_corner_d_y == 0)))
      else $error("zero-depth flag set but no corner is zero");

endmodule

bind rotated_quad_projection rqp_port_checker u_rqp_checker (.*);

`default_nettype wire
